[rtl/rir_pkg.sv]
package rir_pkg;

	localparam int INDEX_W    = 32;
	localparam int RADIX_W    = 8;
	localparam int FRACTION_W = 32;

	localparam int DIGIT_STEPS = 8;

	typedef logic [INDEX_W-1:0]    index_t;
	typedef logic [RADIX_W-1:0]    radix_t;
	typedef logic [FRACTION_W-1:0] fraction_t;

endpackage

[rtl/rir_in_if.sv]
interface rir_in_if;

	logic             valid;
	logic             ready;
	rir_pkg::index_t  index;
	rir_pkg::radix_t  radix;

	modport source (output valid, output index, output radix, input ready);
	modport sink (input valid, input index, input radix, output ready);

endinterface

[rtl/rir_out_if.sv]
interface rir_out_if;

	logic                valid;
	logic                ready;
	rir_pkg::fraction_t  fraction;

	modport source (output valid, output fraction, input ready);
	modport sink (input valid, input fraction, output ready);

endinterface

[rtl/radical_inverse_any_radix.sv]
// Halton radical inverse of a sample index in any radix from 2 to 255.
// Channel sample carries index and radix; channel result carries fraction,
// the mirrored digits as an unsigned Q0.32 value (fraction / 2^32).
// A radix below two or a zero index gives zero. Only the low INDEX_BITS
// bits of index are used.
// One word is worked on at a time. After a word is taken, each base-radix
// digit is found by a shared divider by the radix that retires eight
// quotient bits a cycle; then the multiply state folds the digit into
// the reversed value and the denominator radix^n. A restoring long divider
// then finds FRAC_BITS quotient bits, one quotient bit a cycle, and the
// final state loads the result register. A zero index or a radix below
// two goes straight to the final state.
// sample.ready is high whenever the sequencer is idle, so the next word is
// taken while a finished result still waits. When the receiver stalls, the
// result is held and the sequencer waits in its final state.
// Reset clears the sequencer and the result valid; no clearing pass.
module radical_inverse_any_radix #(
	parameter int INDEX_BITS = 32,
	parameter int FRAC_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	rir_in_if.sink    sample,
	rir_out_if.source result
);

	localparam int RW      = rir_pkg::RADIX_W;
	localparam int OW      = rir_pkg::FRACTION_W;
	localparam int STEP    = rir_pkg::DIGIT_STEPS;
	localparam int DIV_CYC = (INDEX_BITS + STEP - 1) / STEP;
	localparam int WK      = DIV_CYC * STEP;
	localparam int DEN_W   = INDEX_BITS + RW;
	localparam int CNT_W   = $clog2(DIV_CYC + FRAC_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIG  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_LDIV = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WK-1:0]        wk_q;
	logic [RW-1:0]        rad_q;
	logic [RW-1:0]        rem_q;
	logic [DEN_W-1:0]     rev_q;
	logic [DEN_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic                 out_valid_q;
	logic [OW-1:0]        frac_q;

	logic [INDEX_BITS-1:0] idx_lo;
	logic                  accept;
	logic [WK-1:0]         dig_wk;
	logic [RW-1:0]         dig_rem;
	logic [DEN_W+RW-1:0]   mul_rev;
	logic [DEN_W+RW-1:0]   mul_den;
	logic [DEN_W:0]        ld_sh;
	logic [DEN_W:0]        ld_diff;
	logic                  ld_ge;
	logic                  out_free;

	assign idx_lo   = INDEX_BITS'(sample.index);
	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	assign sample.ready    = (state_q == ST_IDLE);
	assign result.valid    = out_valid_q;
	assign result.fraction = frac_q;

	// divide by the radix, eight quotient bits per cycle
	always_comb begin
		logic [RW:0]   t;
		logic [RW-1:0] r;
		logic [WK-1:0] w;
		r = rem_q;
		w = wk_q;
		for (int k = 0; k < STEP; k++) begin
			t = {r, w[WK-1]};
			w = {w[WK-2:0], 1'b0};
			if (t >= {1'b0, rad_q}) begin
				t = t - {1'b0, rad_q};
				w[0] = 1'b1;
			end
			r = t[RW-1:0];
		end
		dig_wk  = w;
		dig_rem = r;
	end

	assign mul_rev = (DEN_W+RW)'(rev_q) * (DEN_W+RW)'(rad_q) + (DEN_W+RW)'(rem_q);
	assign mul_den = (DEN_W+RW)'(den_q) * (DEN_W+RW)'(rad_q);

	assign ld_sh   = {rev_q, 1'b0};
	assign ld_ge   = ld_sh >= {1'b0, den_q};
	assign ld_diff = ld_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (sample.radix < 8'd2 || idx_lo == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIG;
						end
					end
				end
				ST_DIG: begin
					if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (wk_q == '0) begin
						state_q <= ST_LDIV;
					end else begin
						state_q <= ST_DIG;
					end
				end
				ST_LDIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				wk_q  <= WK'(idx_lo);
				rad_q <= sample.radix;
				rem_q <= '0;
				rev_q <= '0;
				den_q <= DEN_W'(1);
				quo_q <= '0;
			end
			ST_DIG: begin
				wk_q  <= dig_wk;
				rem_q <= dig_rem;
			end
			ST_MUL: begin
				rev_q <= mul_rev[DEN_W-1:0];
				den_q <= mul_den[DEN_W-1:0];
				rem_q <= '0;
			end
			ST_LDIV: begin
				if (ld_ge) begin
					rev_q <= ld_diff[DEN_W-1:0];
				end else begin
					rev_q <= ld_sh[DEN_W-1:0];
				end
				quo_q <= {quo_q[FRAC_BITS-2:0], ld_ge};
			end
			ST_FIN: begin
				if (out_free) begin
					frac_q <= OW'(quo_q);
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after taking a word");

	a_digit_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> rem_q < rad_q)
		else $error("digit not below radix");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LDIV |-> rev_q < den_q)
		else $error("long division remainder not below denominator");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result valid raised outside final state");

endmodule
